/* design/bfa_pkg.sv */
// Package: shared types, constants and codes for the best-fit block allocator
package bfa_pkg;
  localparam int TableEntries = 16;
  localparam int OffsetBits   = 20;
  localparam int LenBits      = 21;
  localparam int OutOfsBits   = 20;
  localparam logic [LenBits-1:0] PoolReset = 21'd65536;
  localparam logic [LenBits-1:0] LenMax    = {LenBits{1'b1}};

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic init;
    logic start;
    logic step;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;
endpackage

/* design/bfa_if.sv */
// Interfaces: input command channel and result channel
interface bfa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [bfa_pkg::LenBits-1:0]   block_size;
  logic [bfa_pkg::OutOfsBits-1:0] block_offset;
  modport source (output valid, command, block_size, block_offset, input ready);
  modport sink (input valid, command, block_size, block_offset, output ready);
endinterface

interface bfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::OutOfsBits-1:0] granted_offset;
  logic [1:0]                     status;
  logic [bfa_pkg::LenBits-1:0]    bytes_in_use;
  modport source (output valid, granted_offset, status, bytes_in_use, input ready);
  modport sink (input valid, granted_offset, status, bytes_in_use, output ready);
endinterface

/* design/bfa_ctrl.sv */
// Controller: sequences scan, commit and result handoff
module bfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           res_load,
  input  bfa_pkg::sts_t  sts,
  output bfa_pkg::ctl_t  ctl
);
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !cfg_we;

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    res_load   = 1'b0;
    ctl.init   = cfg_we;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.step = 1'b1;
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        res_load   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

/* design/bfa_datapath.sv */
// Datapath: free and used tables, serial scan and table update
module bfa_datapath #(
  parameter int TABLE_ENTRIES = bfa_pkg::TableEntries,
  parameter int OFFSET_BITS   = bfa_pkg::OffsetBits
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bfa_pkg::LenBits-1:0]    cfg_data,
  input  logic                           in_command,
  input  logic [bfa_pkg::LenBits-1:0]    in_block_size,
  input  logic [bfa_pkg::OutOfsBits-1:0] in_block_offset,
  input  bfa_pkg::ctl_t                  ctl,
  output bfa_pkg::sts_t                  sts,
  output logic [bfa_pkg::OutOfsBits-1:0] res_granted,
  output logic [1:0]                     res_status,
  output logic [bfa_pkg::LenBits-1:0]    res_total
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int LB = bfa_pkg::LenBits;
  localparam int OB = bfa_pkg::OutOfsBits;

  logic [OFFSET_BITS-1:0] fstart_r [TABLE_ENTRIES];
  logic [LB-1:0]          flen_r   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] fvalid_r;
  logic [OFFSET_BITS-1:0] ustart_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] uvalid_r;
  logic [LB-1:0]          total_r;

  logic                   cmd_r;
  logic [LB-1:0]          size_r;
  logic [OFFSET_BITS-1:0] ofs_r;
  logic [CW-1:0]          idx_r;
  logic                   best_ok_r, hit_ok_r, fe_ok_r, ue_ok_r;
  logic [IW-1:0]          best_r, hit_r, fe_r, ue_r;
  logic [LB-1:0]          best_len_r;

  logic [IW-1:0]          idx;
  logic [OFFSET_BITS-1:0] ofs_in;
  logic [LB:0]            sum;
  logic                   fit;

  assign idx = idx_r[IW-1:0];
  assign sts.scan_done = (idx_r == CW'(TABLE_ENTRIES - 1));
  assign fit = fvalid_r[idx] && (flen_r[idx] >= size_r) &&
               (!best_ok_r || flen_r[idx] < best_len_r);
  assign sum = {1'b0, total_r} + {1'b0, size_r};

  generate
    if (OFFSET_BITS >= OB) begin : g_wide
      assign ofs_in = OFFSET_BITS'(in_block_offset);
    end else begin : g_narrow
      assign ofs_in = in_block_offset[OFFSET_BITS-1:0];
    end
  endgenerate

  always_comb begin
    res_granted = '0;
    res_status  = bfa_pkg::ST_OK;
    if (cmd_r == bfa_pkg::CMD_ALLOC) begin
      if (!best_ok_r) res_status = bfa_pkg::ST_NO_FIT;
      else if (!ue_ok_r) res_status = bfa_pkg::ST_FULL;
      else res_granted = OB'({{32{1'b0}}, fstart_r[best_r]});
    end else begin
      if (!hit_ok_r) res_status = bfa_pkg::ST_NOT_FOUND;
      else if (size_r != '0 && !fe_ok_r) res_status = bfa_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      fvalid_r <= {{(TABLE_ENTRIES-1){1'b0}}, (!rst_n ? 1'b1 : (cfg_data != '0))};
      uvalid_r <= '0;
      total_r  <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        fstart_r[i] <= '0;
        flen_r[i]   <= (i == 0) ? (!rst_n ? bfa_pkg::PoolReset : cfg_data) : '0;
      end
    end else if (ctl.start) begin
      cmd_r      <= in_command;
      size_r     <= in_block_size;
      ofs_r      <= ofs_in;
      idx_r      <= '0;
      best_ok_r  <= 1'b0;
      hit_ok_r   <= 1'b0;
      fe_ok_r    <= 1'b0;
      ue_ok_r    <= 1'b0;
      best_r     <= '0;
      hit_r      <= '0;
      fe_r       <= '0;
      ue_r       <= '0;
      best_len_r <= '0;
    end else if (ctl.step) begin
      idx_r <= idx_r + CW'(1);
      if (size_r != '0 && fit) begin
        best_ok_r  <= 1'b1;
        best_r     <= idx;
        best_len_r <= flen_r[idx];
      end
      if (!hit_ok_r && uvalid_r[idx] && ustart_r[idx] == ofs_r) begin
        hit_ok_r <= 1'b1;
        hit_r    <= idx;
      end
      if (!fe_ok_r && !fvalid_r[idx]) begin
        fe_ok_r <= 1'b1;
        fe_r    <= idx;
      end
      if (!ue_ok_r && !uvalid_r[idx]) begin
        ue_ok_r <= 1'b1;
        ue_r    <= idx;
      end
    end else if (ctl.commit && res_status == bfa_pkg::ST_OK) begin
      if (cmd_r == bfa_pkg::CMD_ALLOC) begin
        ustart_r[ue_r] <= fstart_r[best_r];
        uvalid_r[ue_r] <= 1'b1;
        if (flen_r[best_r] == size_r) begin
          fvalid_r[best_r] <= 1'b0;
          fstart_r[best_r] <= '0;
          flen_r[best_r]   <= '0;
        end else begin
          fstart_r[best_r] <= fstart_r[best_r] + OFFSET_BITS'(size_r);
          flen_r[best_r]   <= flen_r[best_r] - size_r;
        end
        total_r <= sum[LB] ? bfa_pkg::LenMax : sum[LB-1:0];
      end else begin
        uvalid_r[hit_r] <= 1'b0;
        if (size_r != '0) begin
          fstart_r[fe_r] <= ofs_r;
          flen_r[fe_r]   <= size_r;
          fvalid_r[fe_r] <= 1'b1;
        end
        total_r <= (total_r > size_r) ? total_r - size_r : '0;
      end
    end
  end

  always_comb res_total = (ctl.commit && res_status == bfa_pkg::ST_OK) ?
    ((cmd_r == bfa_pkg::CMD_ALLOC) ? (sum[LB] ? bfa_pkg::LenMax : sum[LB-1:0]) :
     ((total_r > size_r) ? total_r - size_r : '0)) : total_r;
endmodule

/* design/best_fit_block_allocator_unit.sv */
// Top level: best-fit block allocator with output register
// Each command passes through an accept step, a scan step per table slot through a
// single compare unit that walks the free and used tables together, and a commit step
// that updates the tables and loads the result register. A new command is taken only
// while the controller is idle and the output register is empty or being read.
// Writing cfg_data reinitializes both tables at once to one free block of cfg_data
// bytes covering the pool, or to no free block when cfg_data is zero.
module best_fit_block_allocator_unit #(
  parameter int TABLE_ENTRIES = bfa_pkg::TableEntries,
  parameter int OFFSET_BITS   = bfa_pkg::OffsetBits
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bfa_pkg::LenBits-1:0] cfg_data,
  bfa_in_if.sink                      in_ch,
  bfa_out_if.source                   out_ch
);
  bfa_pkg::ctl_t ctl;
  bfa_pkg::sts_t sts;
  logic ctrl_ready, res_load, out_valid_r;
  logic [bfa_pkg::OutOfsBits-1:0] g_r, g;
  logic [1:0] s_r, s;
  logic [bfa_pkg::LenBits-1:0] t_r, t;

  assign in_ch.ready = ctrl_ready && (!out_valid_r || out_ch.ready);

  bfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
    .in_valid(in_ch.valid && (!out_valid_r || out_ch.ready)),
    .in_ready(ctrl_ready), .res_load(res_load), .sts(sts), .ctl(ctl)
  );

  bfa_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_data(cfg_data),
    .in_command(in_ch.command), .in_block_size(in_ch.block_size),
    .in_block_offset(in_ch.block_offset), .ctl(ctl), .sts(sts),
    .res_granted(g), .res_status(s), .res_total(t)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (res_load) begin
      g_r <= g;
      s_r <= s;
      t_r <= t;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted_offset = g_r;
  assign out_ch.status         = s_r;
  assign out_ch.bytes_in_use   = t_r;
endmodule

/* test/tb_best_fit_block_allocator_unit.sv */
// Testbench: directed and random allocate/free traffic checked against a best-fit pool predictor
`timescale 1ns / 1ps
module tb_best_fit_block_allocator_unit;
  typedef struct packed {
    logic [bfa_pkg::OutOfsBits-1:0] offset;
    bfa_pkg::status_t               status;
    logic [bfa_pkg::LenBits-1:0]    in_use;
  } grant_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bfa_pkg::LenBits-1:0] cfg_data;
  int send_idle_pct;
  int recv_idle_pct;
  int errors;

  bfa_in_if  in_ch();
  bfa_out_if out_ch();

  best_fit_block_allocator_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic [bfa_pkg::OffsetBits-1:0] hole_start [bfa_pkg::TableEntries];
  logic [bfa_pkg::LenBits-1:0]    hole_len   [bfa_pkg::TableEntries];
  bit                             hole_live  [bfa_pkg::TableEntries];
  logic [bfa_pkg::OffsetBits-1:0] lease_start[bfa_pkg::TableEntries];
  bit                             lease_live [bfa_pkg::TableEntries];
  logic [bfa_pkg::LenBits-1:0]    pool_size;
  logic [bfa_pkg::LenBits-1:0]    in_use_sum;
  grant_t                         pending_grants[$];
  logic [bfa_pkg::OffsetBits-1:0] granted_list[$];
  logic [bfa_pkg::LenBits-1:0]    granted_sizes[$];

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic void reset_pool(input logic [bfa_pkg::LenBits-1:0] bytes);
    pool_size = bytes;
    for (int i = 0; i < bfa_pkg::TableEntries; i++) begin
      hole_start[i] = '0; hole_len[i] = '0; hole_live[i] = 0;
      lease_start[i] = '0; lease_live[i] = 0;
    end
    hole_len[0] = bytes;
    hole_live[0] = (bytes != '0);
    in_use_sum = '0;
    granted_list.delete();
    granted_sizes.delete();
  endfunction

  function automatic grant_t predict_grant(input bfa_pkg::cmd_t cmd,
                                           input logic [bfa_pkg::LenBits-1:0] size,
                                           input logic [bfa_pkg::OffsetBits-1:0] ofs);
    grant_t g;
    int best;
    int slot;
    logic [bfa_pkg::LenBits:0] sum;
    g = '{offset: '0, status: bfa_pkg::ST_OK, in_use: '0};
    best = -1;
    slot = -1;
    if (cmd == bfa_pkg::CMD_ALLOC) begin
      if (size != '0)
        for (int i = 0; i < bfa_pkg::TableEntries; i++)
          if (hole_live[i] && hole_len[i] >= size &&
              (best < 0 || hole_len[i] < hole_len[best]))
            best = i;
      for (int i = bfa_pkg::TableEntries - 1; i >= 0; i--) if (!lease_live[i]) slot = i;
      if (best < 0) g.status = bfa_pkg::ST_NO_FIT;
      else if (slot < 0) g.status = bfa_pkg::ST_FULL;
      else begin
        g.offset = hole_start[best];
        lease_start[slot] = hole_start[best];
        lease_live[slot] = 1;
        granted_list.push_back(hole_start[best]);
        granted_sizes.push_back(size);
        if (hole_len[best] == size) begin
          hole_live[best] = 0; hole_start[best] = '0; hole_len[best] = '0;
        end else begin
          hole_start[best] = hole_start[best] + size[bfa_pkg::OffsetBits-1:0];
          hole_len[best] = hole_len[best] - size;
        end
        sum = {1'b0, in_use_sum} + {1'b0, size};
        in_use_sum = sum[bfa_pkg::LenBits] ? bfa_pkg::LenMax : sum[bfa_pkg::LenBits-1:0];
      end
    end else begin
      for (int i = bfa_pkg::TableEntries - 1; i >= 0; i--) if (!hole_live[i]) slot = i;
      for (int i = bfa_pkg::TableEntries - 1; i >= 0; i--)
        if (lease_live[i] && lease_start[i] == ofs) best = i;
      if (best < 0) g.status = bfa_pkg::ST_NOT_FOUND;
      else if (size != '0 && slot < 0) g.status = bfa_pkg::ST_FULL;
      else begin
        lease_live[best] = 0;
        if (size != '0) begin
          hole_start[slot] = ofs; hole_len[slot] = size; hole_live[slot] = 1;
        end
        in_use_sum = (in_use_sum > size) ? in_use_sum - size : '0;
      end
    end
    g.in_use = in_use_sum;
    return g;
  endfunction

  task automatic send_command(input bfa_pkg::cmd_t cmd,
                              input logic [bfa_pkg::LenBits-1:0] size,
                              input logic [bfa_pkg::OffsetBits-1:0] ofs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.block_size <= size;
    in_ch.block_offset <= ofs;
    pending_grants.push_back(predict_grant(cmd, size, ofs));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_and_write_pool(input logic [bfa_pkg::LenBits-1:0] bytes);
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (bfa_pkg::TableEntries + 6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    reset_pool(bytes);
  endtask

  task automatic free_random_grant(input bit exact);
    int k;
    logic [bfa_pkg::LenBits-1:0] sz;
    k = $urandom_range(granted_list.size() - 1);
    sz = exact ? granted_sizes[k] : bfa_pkg::LenBits'($urandom_range(64));
    send_command(bfa_pkg::CMD_FREE, sz, granted_list[k]);
    granted_list.delete(k);
    granted_sizes.delete(k);
  endtask

  task automatic test_directed();
    send_command(bfa_pkg::CMD_ALLOC, 21'd0, '1);
    send_command(bfa_pkg::CMD_ALLOC, 21'd1048576, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'd5, 20'd12345);
    send_command(bfa_pkg::CMD_ALLOC, 21'd100, 20'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd200, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'd100, 20'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd50, 20'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd50, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'd0, 20'd100);
    for (int i = 0; i < 15; i++) send_command(bfa_pkg::CMD_ALLOC, 21'd1, 20'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd1, 20'd0);
    drain_and_write_pool(21'd1048576);
    send_command(bfa_pkg::CMD_ALLOC, 21'd1048576, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'h1FFFFF, 20'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd1048575, 20'd0);
    drain_and_write_pool(21'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd1, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'd1, 20'd0);
    drain_and_write_pool(21'h1FFFFF);
    send_command(bfa_pkg::CMD_ALLOC, 21'h1FFFFF, 20'd0);
    send_command(bfa_pkg::CMD_ALLOC, 21'd1, 20'd0);
  endtask

  task automatic test_free_table_full();
    drain_and_write_pool(21'd64);
    for (int i = 0; i < 16; i++) send_command(bfa_pkg::CMD_ALLOC, 21'd4, 20'd0);
    for (int i = 0; i < 16; i++) send_command(bfa_pkg::CMD_FREE, 21'd4, 20'(4 * i));
    for (int i = 0; i < 16; i++) send_command(bfa_pkg::CMD_ALLOC, 21'd4, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'd1, 20'd0);
    send_command(bfa_pkg::CMD_FREE, 21'd0, 20'd4);
  endtask

  task automatic test_random(input int count, input logic [bfa_pkg::LenBits-1:0] bytes);
    int r;
    drain_and_write_pool(bytes);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45)
        send_command(bfa_pkg::CMD_ALLOC,
                     bfa_pkg::LenBits'($urandom_range(1, (bytes >> 4) + 1)), '0);
      else if (r < 80 && granted_list.size() != 0) free_random_grant(1);
      else if (r < 88 && granted_list.size() != 0) free_random_grant(0);
      else if (r < 95)
        send_command(bfa_pkg::cmd_t'($urandom_range(1)), bfa_pkg::LenBits'($urandom),
                     bfa_pkg::OffsetBits'($urandom));
      else
        send_command(bfa_pkg::CMD_ALLOC, bfa_pkg::LenBits'($urandom_range(bytes)),
                     bfa_pkg::OffsetBits'($urandom));
    end
  endtask

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{offset: out_ch.granted_offset, status: bfa_pkg::status_t'(out_ch.status),
                in_use: out_ch.bytes_in_use};
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = pending_grants.pop_front();
          if (got.offset !== want.offset) begin
            $display("%0t: granted_offset expected %0d actual %0d", $time, want.offset,
                     got.offset);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.in_use !== want.in_use) begin
            $display("%0t: bytes_in_use expected %0d actual %0d", $time, want.in_use,
                     got.in_use);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #80_000_000;
    $display("best_fit_block_allocator_unit regression: fail");
    $finish;
  end

  initial begin
    errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = bfa_pkg::CMD_ALLOC;
    in_ch.block_size = '0;
    in_ch.block_offset = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 62;
    reset_pool(bfa_pkg::PoolReset);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_free_table_full();
    test_random(250, 21'd4096);
    test_random(250, 21'd256);
    send_idle_pct = 62;
    recv_idle_pct = 20;
    test_random(250, 21'd65536);
    test_random(250, 21'h1FFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250, 21'd512);
    test_random(250, 21'd1);
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (bfa_pkg::TableEntries + 6) @(posedge clk);
    if (errors == 0 && pending_grants.size() == 0)
      $display("best_fit_block_allocator_unit regression: pass");
    else
      $display("best_fit_block_allocator_unit regression: fail");
    $finish;
  end
endmodule
